// ===== rtl/core/branch_unit_with_call_stack_top_macros.svh =====
// Assertion macros for the branch unit with call stack.
`ifndef BRANCH_UNIT_WITH_CALL_STACK_TOP_MACROS_SVH
`define BRANCH_UNIT_WITH_CALL_STACK_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define BUCS_ASSERT_PROP(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// expression must never be true outside reset
`define BUCS_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define BUCS_ASSERT_PROP(label, prop)
`define BUCS_ASSERT_NEVER(label, expr)

`endif

`endif

// ===== rtl/core/bucs_pkg.sv =====
// Shared types, opcodes and status codes of the branch unit with call stack.
package bucs_pkg;

    localparam int PC_W           = 32;
    localparam int MODE_W         = 8;
    localparam int STATUS_W       = 2;
    localparam int CALL_DEPTH_DEF = 16;
    localparam int IN_TDATA_W     = 80;
    localparam int OUT_TDATA_W    = 40;

    // opcodes
    localparam logic [MODE_W-1:0] OP_JMP  = 8'h0B;
    localparam logic [MODE_W-1:0] OP_CALL = 8'h0C;
    localparam logic [MODE_W-1:0] OP_RET  = 8'h0D;
    localparam logic [MODE_W-1:0] OP_JC   = 8'h0E;
    localparam logic [MODE_W-1:0] OP_JNC  = 8'h0F;
    localparam logic [MODE_W-1:0] OP_JZ   = 8'h10;
    localparam logic [MODE_W-1:0] OP_JNZ  = 8'h11;
    localparam logic [MODE_W-1:0] OP_JV   = 8'h12;
    localparam logic [MODE_W-1:0] OP_JNV  = 8'h13;
    localparam logic [MODE_W-1:0] OP_JMI  = 8'h14;
    localparam logic [MODE_W-1:0] OP_JPL  = 8'h15;
    localparam logic [MODE_W-1:0] OP_JT   = 8'h47;
    localparam logic [MODE_W-1:0] OP_JNT  = 8'h48;
    localparam logic [MODE_W-1:0] OP_JG   = 8'h5A;
    localparam logic [MODE_W-1:0] OP_JNL  = 8'h5B;
    localparam logic [MODE_W-1:0] OP_JL   = 8'h5C;
    localparam logic [MODE_W-1:0] OP_JNG  = 8'h5D;
    localparam logic [MODE_W-1:0] OP_JA   = 8'h5E;
    localparam logic [MODE_W-1:0] OP_JNA  = 8'h5F;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ILLEGAL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [PC_W-1:0]   current_pc;
        logic              target_is_absolute;
        logic [PC_W-1:0]   operand_value;
        logic              flag_carry;
        logic              flag_zero;
        logic              flag_overflow;
        logic              flag_sign;
        logic              trap_match;
    } in_item_t;

    typedef struct packed {
        logic [PC_W-1:0]     next_pc;
        logic                branch_taken;
        logic [STATUS_W-1:0] status;
    } result_t;

    // stack update request, already qualified by the pipeline advance
    typedef struct packed {
        logic            push;
        logic            pop;
        logic [PC_W-1:0] push_pc;
    } stack_req_t;

    typedef struct packed {
        logic            full;
        logic            empty;
        logic [PC_W-1:0] top;
    } stack_stat_t;

endpackage

// ===== rtl/core/bucs_stack.sv =====
// Return stack: top entry in a register, prefetched second entry, rest in memory.
module bucs_stack #(
    parameter int CALL_DEPTH = bucs_pkg::CALL_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  bucs_pkg::stack_req_t     req,
    output bucs_pkg::stack_stat_t    stat
);

    localparam int CW = $clog2(CALL_DEPTH + 1);
    localparam int AW = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;

    logic [CW-1:0]             cnt_reg;
    logic [CW-1:0]             cnt_next;
    logic [bucs_pkg::PC_W-1:0] tos_reg;
    logic [bucs_pkg::PC_W-1:0] below_reg;
    logic [bucs_pkg::PC_W-1:0] mem [CALL_DEPTH];
    logic [CW-1:0]             wr_cnt;
    logic [CW-1:0]             rd_cnt;
    logic [AW-1:0]             wr_addr;
    logic [AW-1:0]             rd_addr;

    always_comb
    begin
        if (req.push)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (req.pop)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    // old top spills to memory slot count-1; prefetch slot newcount-2
    assign wr_cnt  = cnt_reg - CW'(1);
    assign rd_cnt  = cnt_next - CW'(2);
    assign wr_addr = wr_cnt[AW-1:0];
    assign rd_addr = rd_cnt[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.push && (cnt_reg != '0))
        begin
            mem[wr_addr] <= tos_reg;
        end
    end

    // a push makes the old top the second entry, bypassing the memory write
    always_ff @(posedge clk)
    begin
        if (req.push)
        begin
            below_reg <= tos_reg;
        end
        else
        begin
            below_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.push)
        begin
            tos_reg <= req.push_pc;
        end
        else if (req.pop)
        begin
            tos_reg <= below_reg;
        end
    end

    assign stat.full  = (cnt_reg == CW'(CALL_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign stat.top   = tos_reg;

endmodule

// ===== rtl/core/bucs_exec.sv =====
// Opcode decode, condition test and branch target for one instruction.
module bucs_exec (
    input  logic                  en,
    input  bucs_pkg::in_item_t    item,
    input  bucs_pkg::stack_stat_t stat,
    output bucs_pkg::result_t     res,
    output bucs_pkg::stack_req_t  req
);

    logic                      is_cond;
    logic                      cond;
    logic                      do_push;
    logic                      do_pop;
    logic [bucs_pkg::PC_W-1:0] target;
    logic                      c;
    logic                      z;
    logic                      v;
    logic                      s;

    assign c = item.flag_carry;
    assign z = item.flag_zero;
    assign v = item.flag_overflow;
    assign s = item.flag_sign;

    // absolute target is the operand itself, the same as pc + (target - pc) after wrap
    assign target = item.target_is_absolute ? item.operand_value
                                            : item.current_pc + item.operand_value;

    always_comb
    begin
        is_cond     = 1'b1;
        cond        = 1'b0;
        do_push     = 1'b0;
        do_pop      = 1'b0;
        res.next_pc = item.current_pc;
        res.branch_taken = 1'b0;
        res.status  = bucs_pkg::ST_OK;
        case (item.mode)
            bucs_pkg::OP_JMP:  cond = 1'b1;
            bucs_pkg::OP_CALL:
            begin
                is_cond = 1'b0;
                if (stat.full)
                begin
                    res.status = bucs_pkg::ST_OVERFLOW;
                end
                else
                begin
                    do_push          = 1'b1;
                    res.next_pc      = target;
                    res.branch_taken = 1'b1;
                end
            end
            bucs_pkg::OP_RET:
            begin
                is_cond = 1'b0;
                if (stat.empty)
                begin
                    res.status = bucs_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    do_pop           = 1'b1;
                    res.next_pc      = stat.top;
                    res.branch_taken = 1'b1;
                end
            end
            bucs_pkg::OP_JC:   cond = c;
            bucs_pkg::OP_JNC:  cond = !c;
            bucs_pkg::OP_JZ:   cond = z;
            bucs_pkg::OP_JNZ:  cond = !z;
            bucs_pkg::OP_JV:   cond = v;
            bucs_pkg::OP_JNV:  cond = !v;
            bucs_pkg::OP_JMI:  cond = s;
            bucs_pkg::OP_JPL:  cond = !s;
            bucs_pkg::OP_JT:   cond = item.trap_match;
            bucs_pkg::OP_JNT:  cond = !item.trap_match;
            bucs_pkg::OP_JG:   cond = !z && (s == v);
            bucs_pkg::OP_JNL:  cond = (s == v);
            bucs_pkg::OP_JL:   cond = (s != v);
            bucs_pkg::OP_JNG:  cond = z || (s != v);
            bucs_pkg::OP_JA:   cond = !c && !z;
            bucs_pkg::OP_JNA:  cond = c || z;
            default:
            begin
                is_cond    = 1'b0;
                res.status = bucs_pkg::ST_ILLEGAL;
            end
        endcase
        if (is_cond && cond)
        begin
            res.next_pc      = target;
            res.branch_taken = 1'b1;
        end
    end

    assign req.push    = en && do_push;
    assign req.pop     = en && do_pop;
    assign req.push_pc = item.current_pc;

endmodule

// ===== rtl/core/branch_unit_with_call_stack_top.sv =====
// Top level of the branch unit with call stack: stream ports and pipeline registers.
//
// Executes one control-flow instruction per transfer and returns the next PC, a taken
// flag and a status (ok, illegal opcode, stack overflow, stack underflow). Throughput
// is one instruction per cycle unless m_tready holds back the result register; an
// instruction passes through the input register, then the result register. The
// return stack is updated in the same cycle an instruction moves from the input
// register into the result register, and its next-to-top entry is kept prefetched
// from the stack memory, so back-to-back call and ret run at full rate. CALL_DEPTH
// sets the stack depth; no clearing pass is needed after reset.
module branch_unit_with_call_stack_top #(
    parameter int CALL_DEPTH = bucs_pkg::CALL_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // mode[7:0], current_pc[39:8], operand_value[71:40], flag_carry[72],
    // flag_zero[73], flag_overflow[74], flag_sign[75], trap_match[76], zero[79:77]
    input  logic [bucs_pkg::IN_TDATA_W-1:0]   s_tdata,
    // target_is_absolute[0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // next_pc[31:0], branch_taken[32], status[34:33], zero[39:35]
    output logic [bucs_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    logic                  in_v_reg;
    logic                  in_v_next;
    bucs_pkg::in_item_t    in_reg;
    logic                  out_v_reg;
    logic                  out_v_next;
    bucs_pkg::result_t     out_reg;
    bucs_pkg::result_t     res;
    bucs_pkg::stack_req_t  stk_req;
    bucs_pkg::stack_stat_t stk_stat;
    logic                  s_fire;
    logic                  m_fire;
    logic                  adv;

    assign adv      = in_v_reg && (!out_v_reg || m_tready);
    assign s_tready = !in_v_reg || adv;
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = out_v_reg && m_tready;

    always_comb
    begin
        if (s_fire)
        begin
            in_v_next = 1'b1;
        end
        else if (adv)
        begin
            in_v_next = 1'b0;
        end
        else
        begin
            in_v_next = in_v_reg;
        end

        if (adv)
        begin
            out_v_next = 1'b1;
        end
        else if (m_fire)
        begin
            out_v_next = 1'b0;
        end
        else
        begin
            out_v_next = out_v_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg  <= in_v_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_reg.mode               <= s_tdata[7:0];
            in_reg.current_pc         <= s_tdata[39:8];
            in_reg.target_is_absolute <= s_tuser;
            in_reg.operand_value      <= s_tdata[71:40];
            in_reg.flag_carry         <= s_tdata[72];
            in_reg.flag_zero          <= s_tdata[73];
            in_reg.flag_overflow      <= s_tdata[74];
            in_reg.flag_sign          <= s_tdata[75];
            in_reg.trap_match         <= s_tdata[76];
        end
        if (adv)
        begin
            out_reg <= res;
        end
    end

    bucs_exec u_exec (
        .en   (adv),
        .item (in_reg),
        .stat (stk_stat),
        .res  (res),
        .req  (stk_req)
    );

    bucs_stack #(
        .CALL_DEPTH (CALL_DEPTH)
    ) u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (stk_req),
        .stat  (stk_stat)
    );

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {5'd0, out_reg.status, out_reg.branch_taken, out_reg.next_pc};

`include "branch_unit_with_call_stack_top_macros.svh"

    `BUCS_ASSERT_NEVER(a_full_and_empty, stk_stat.full && stk_stat.empty)
    `BUCS_ASSERT_NEVER(a_err_taken, out_v_reg && (out_reg.status != bucs_pkg::ST_OK) && out_reg.branch_taken)
    `BUCS_ASSERT_PROP(a_call_full, (adv && (in_reg.mode == bucs_pkg::OP_CALL) && stk_stat.full) |=> (out_reg.status == bucs_pkg::ST_OVERFLOW))
    `BUCS_ASSERT_PROP(a_ret_empty, (adv && (in_reg.mode == bucs_pkg::OP_RET) && stk_stat.empty) |=> (out_reg.status == bucs_pkg::ST_UNDERFLOW))

endmodule

// ===== bench/tb_branch_unit_with_call_stack_top.sv =====
// Stream testbench for the branch unit: directed and random instructions against a predictor.
`timescale 1ns / 1ps

module tb_branch_unit_with_call_stack_top;

    localparam int DEPTH      = bucs_pkg::CALL_DEPTH_DEF;
    localparam int N_RANDOM   = 800;
    localparam int IDLE_LIMIT = 4000;

    // jmp and every flag or trap conditional jump
    localparam logic [bucs_pkg::MODE_W-1:0] JUMP_OPS [17] = '{
        bucs_pkg::OP_JMP, bucs_pkg::OP_JC, bucs_pkg::OP_JNC, bucs_pkg::OP_JZ,
        bucs_pkg::OP_JNZ, bucs_pkg::OP_JV, bucs_pkg::OP_JNV, bucs_pkg::OP_JMI,
        bucs_pkg::OP_JPL, bucs_pkg::OP_JT, bucs_pkg::OP_JNT, bucs_pkg::OP_JG,
        bucs_pkg::OP_JNL, bucs_pkg::OP_JL, bucs_pkg::OP_JNG, bucs_pkg::OP_JA,
        bucs_pkg::OP_JNA
    };

    // Predicts each instruction and holds the results still owed by the block.
    class branch_scoreboard;
        logic [bucs_pkg::PC_W-1:0] ret_stack [DEPTH];
        int unsigned               depth_used;
        bucs_pkg::result_t         owed [$];
        int                        errors;
        int                        n_items;
        int                        n_taken;
        int                        n_illegal;
        int                        n_overflow;
        int                        n_underflow;

        function new();
            depth_used = 0;
            errors     = 0;
            n_items    = 0;
            n_taken    = 0;
            n_illegal  = 0;
            n_overflow = 0;
            n_underflow = 0;
        endfunction

        function void note_input(bucs_pkg::in_item_t it);
            bucs_pkg::result_t         res;
            logic [bucs_pkg::PC_W-1:0] offset;
            logic [bucs_pkg::PC_W-1:0] target;
            logic                      jump_op;
            logic                      cond;
            offset  = it.target_is_absolute ? it.operand_value - it.current_pc
                                            : it.operand_value;
            target  = it.current_pc + offset;
            res.next_pc      = it.current_pc;
            res.branch_taken = 1'b0;
            res.status       = bucs_pkg::ST_OK;
            jump_op = 1'b1;
            cond    = 1'b0;
            case (it.mode)
                bucs_pkg::OP_JMP:  cond = 1'b1;
                bucs_pkg::OP_CALL:
                begin
                    jump_op = 1'b0;
                    if (depth_used >= DEPTH)
                        res.status = bucs_pkg::ST_OVERFLOW;
                    else
                    begin
                        ret_stack[depth_used] = it.current_pc;
                        depth_used++;
                        res.next_pc      = target;
                        res.branch_taken = 1'b1;
                    end
                end
                bucs_pkg::OP_RET:
                begin
                    jump_op = 1'b0;
                    if (depth_used == 0)
                        res.status = bucs_pkg::ST_UNDERFLOW;
                    else
                    begin
                        depth_used--;
                        res.next_pc      = ret_stack[depth_used];
                        res.branch_taken = 1'b1;
                    end
                end
                bucs_pkg::OP_JC:   cond = it.flag_carry;
                bucs_pkg::OP_JNC:  cond = !it.flag_carry;
                bucs_pkg::OP_JZ:   cond = it.flag_zero;
                bucs_pkg::OP_JNZ:  cond = !it.flag_zero;
                bucs_pkg::OP_JV:   cond = it.flag_overflow;
                bucs_pkg::OP_JNV:  cond = !it.flag_overflow;
                bucs_pkg::OP_JMI:  cond = it.flag_sign;
                bucs_pkg::OP_JPL:  cond = !it.flag_sign;
                bucs_pkg::OP_JT:   cond = it.trap_match;
                bucs_pkg::OP_JNT:  cond = !it.trap_match;
                bucs_pkg::OP_JG:
                    cond = !it.flag_zero && (it.flag_sign == it.flag_overflow);
                bucs_pkg::OP_JNL:  cond = (it.flag_sign == it.flag_overflow);
                bucs_pkg::OP_JL:   cond = (it.flag_sign != it.flag_overflow);
                bucs_pkg::OP_JNG:
                    cond = it.flag_zero || (it.flag_sign != it.flag_overflow);
                bucs_pkg::OP_JA:   cond = !it.flag_carry && !it.flag_zero;
                bucs_pkg::OP_JNA:  cond = it.flag_carry || it.flag_zero;
                default:
                begin
                    jump_op    = 1'b0;
                    res.status = bucs_pkg::ST_ILLEGAL;
                end
            endcase
            if (jump_op && cond)
            begin
                res.next_pc      = target;
                res.branch_taken = 1'b1;
            end
            n_items++;
            if (res.branch_taken)
                n_taken++;
            case (res.status)
                bucs_pkg::ST_ILLEGAL:   n_illegal++;
                bucs_pkg::ST_OVERFLOW:  n_overflow++;
                bucs_pkg::ST_UNDERFLOW: n_underflow++;
                default: ;
            endcase
            owed.push_back(res);
        endfunction

        function void check_result(logic [bucs_pkg::OUT_TDATA_W-1:0] data);
            bucs_pkg::result_t want;
            if (owed.size() == 0)
            begin
                $display("%0t: result %h arrived with nothing expected", $time, data);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (data[31:0] !== want.next_pc)
            begin
                $display("%0t: next_pc expected %h, got %h", $time, want.next_pc, data[31:0]);
                errors++;
            end
            if (data[32] !== want.branch_taken)
            begin
                $display("%0t: branch_taken expected %b, got %b", $time,
                         want.branch_taken, data[32]);
                errors++;
            end
            if (data[34:33] !== want.status)
            begin
                $display("%0t: status expected %0d, got %0d", $time, want.status, data[34:33]);
                errors++;
            end
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n    = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [bucs_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                             s_tuser  = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [bucs_pkg::OUT_TDATA_W-1:0] m_tdata;

    branch_scoreboard sb;
    int               burst_left = 0;
    int               idle_cycles = 0;
    int               ready_left = 0;
    int               ready_kind = 0;
    logic             call_bias = 1'b1;

    branch_unit_with_call_stack_top #(
        .CALL_DEPTH(DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver: segments of always ready, coin flip, and mostly stalled
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_kind <= $urandom_range(0, 2);
            ready_left <= $urandom_range(4, 40);
        end
        else
            ready_left <= ready_left - 1;
        case (ready_kind)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, %0d results still owed",
                     $time, IDLE_LIMIT, sb.owed.size());
            $display("tb_branch_unit_with_call_stack_top: done, errors");
            $finish;
        end
    end

    function automatic bucs_pkg::in_item_t make_item(logic [bucs_pkg::MODE_W-1:0] mode,
                                                     logic [bucs_pkg::PC_W-1:0] pc,
                                                     logic absolute,
                                                     logic [bucs_pkg::PC_W-1:0] operand);
        bucs_pkg::in_item_t it;
        it.mode               = mode;
        it.current_pc         = pc;
        it.target_is_absolute = absolute;
        it.operand_value      = operand;
        it.flag_carry         = 1'($urandom_range(0, 1));
        it.flag_zero          = 1'($urandom_range(0, 1));
        it.flag_overflow      = 1'($urandom_range(0, 1));
        it.flag_sign          = 1'($urandom_range(0, 1));
        it.trap_match         = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic logic [bucs_pkg::PC_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // bursts of back-to-back transfers with random gaps in between
    task automatic send_item(input bucs_pkg::in_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 12);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= it.target_is_absolute;
        s_tdata  <= {3'b000, it.trap_match, it.flag_sign, it.flag_overflow, it.flag_zero,
                     it.flag_carry, it.operand_value, it.current_pc, it.mode};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_input(it);
    endtask

    task automatic send_random();
        int                          r;
        logic [bucs_pkg::MODE_W-1:0] mode;
        r = $urandom_range(0, 99);
        // swing the stack between empty and full so both error paths get hit
        if (sb.depth_used >= DEPTH && $urandom_range(0, 3) == 0)
            call_bias = 1'b0;
        else if (sb.depth_used == 0 && $urandom_range(0, 3) == 0)
            call_bias = 1'b1;
        if (r < 8)
            mode = 8'($urandom_range(0, 255));
        else if (r < 45)
            mode = (($urandom_range(0, 9) < 7) == call_bias) ? bucs_pkg::OP_CALL
                                                               : bucs_pkg::OP_RET;
        else
            mode = JUMP_OPS[$urandom_range(0, 16)];
        send_item(make_item(mode, pick_word(), 1'($urandom_range(0, 1)), pick_word()));
    endtask

    initial
    begin
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty-stack ret, wrapping targets, call/ret pair, each jump, illegal ends
        send_item(make_item(bucs_pkg::OP_RET, 32'h0000_1000, 1'b0, 32'h0000_0010));
        send_item(make_item(bucs_pkg::OP_JMP, 32'h0000_0000, 1'b0, 32'h7FFF_FFFF));
        send_item(make_item(bucs_pkg::OP_JMP, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000));
        send_item(make_item(bucs_pkg::OP_CALL, 32'hFFFF_FFF0, 1'b0, 32'h8000_0000));
        send_item(make_item(bucs_pkg::OP_CALL, 32'h0000_0004, 1'b1, 32'hFFFF_FFFF));
        send_item(make_item(bucs_pkg::OP_RET, 32'h1234_5678, 1'b1, 32'hFFFF_FFFF));
        for (int i = 1; i < 17; i++)
            send_item(make_item(JUMP_OPS[i], $urandom, i[0], $urandom));
        send_item(make_item(8'h00, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000));
        send_item(make_item(8'hFF, 32'h0000_0000, 1'b0, 32'h7FFF_FFFF));

        for (int i = 0; i < N_RANDOM; i++)
            send_random();

        s_tvalid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("%0d instructions checked: %0d taken, %0d illegal opcode,",
                 sb.n_items, sb.n_taken, sb.n_illegal);
        $display("%0d call on full stack, %0d ret on empty stack",
                 sb.n_overflow, sb.n_underflow);
        if (sb.errors == 0)
            $display("tb_branch_unit_with_call_stack_top: done, clean");
        else
            $display("tb_branch_unit_with_call_stack_top: done, errors");
        $finish;
    end

endmodule
